// File: hw/rtl/sample_mean_variance_stddev_unit_macros.svh
// Assertion macros for the sample mean/variance/deviation unit.
`ifndef SAMPLE_MEAN_VARIANCE_STDDEV_UNIT_MACROS_SVH
`define SAMPLE_MEAN_VARIANCE_STDDEV_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SMVS_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SMVS_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/smvs_pkg.sv
// Package: widths, status codes and sequencer types of the mean/variance unit.
`timescale 1ns / 1ps
`default_nettype none

package smvs_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int MEAN_W     = 32;
  localparam int VAR_W      = 56;
  localparam int DEV_W      = 32;
  localparam int COUNT_W    = 17;
  localparam int STATUS_W   = 2;
  localparam int MAX_COUNT  = 65536;

  localparam int SUM_W      = 40;
  localparam int SQ_W       = 63;
  localparam int MUL_W      = 32;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int ACC_W      = 82;
  localparam int DIFF_W     = 80;
  localparam int FRAC_W     = 8;
  localparam int VAR_SHIFT  = 2 * FRAC_W;
  localparam int DVD_W      = DIFF_W + VAR_SHIFT;
  localparam int DVS_W      = 33;
  localparam int MEAN_NUM_W = SUM_W + FRAC_W;
  localparam int ROOT_W     = 64;
  localparam int ROOT_STEPS = ROOT_W / 2;
  localparam int IT_W       = 7;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK  = 2'd0,
    STAT_FEW = 2'd1,
    STAT_OVF = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_MUL,
    ST_MEAN,
    ST_VAR,
    ST_ROOT,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    MS_DIVISOR,
    MS_SQ_LO,
    MS_SQ_HI,
    MS_SM_LL,
    MS_SM_LH,
    MS_SM_HH,
    MS_DRAIN
  } mul_step_t;

endpackage

`default_nettype wire

// File: hw/rtl/smvs_if.sv
// Channel interfaces: sample input, statistics output and mode write.
`timescale 1ns / 1ps
`default_nettype none

interface smvs_in_if;
  import smvs_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;
  modport source (output valid, sample, last, input ready);
  modport sink (input valid, sample, last, output ready);
endinterface

interface smvs_out_if;
  import smvs_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [MEAN_W-1:0] mean_value;
  logic [VAR_W-1:0]         variance_value;
  logic [DEV_W-1:0]         std_dev;
  logic [COUNT_W-1:0]       sample_count;
  logic [STATUS_W-1:0]      status;
  modport source (output valid, mean_value, variance_value, std_dev, sample_count, status,
                  input ready);
  modport sink (input valid, mean_value, variance_value, std_dev, sample_count, status,
                output ready);
endinterface

interface smvs_cfg_if;
  logic valid;
  logic ready;
  logic population_mode;
  modport source (output valid, population_mode, input ready);
  modport sink (input valid, population_mode, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/sample_mean_variance_stddev_unit.sv
// Top level: running mean, variance and standard deviation of a sample set.
// in_chan carries one signed 24-bit sample per word, last marks the end of a set.
// out_chan carries one word per set: floored mean, truncated variance and
// deviation (8 fraction bits each), the sample count and a status code.
// cfg_chan writes population_mode (1: divide by n, 0: by n-1); always ready.
// A sample that does not end a set drops in_ready in the cycle after the
// accept. The word that ends a set starts the finish sequence: partial
// products on the shared 32x32 multiplier, the restoring divider for the
// mean and then the variance, and the bit-pair square root; a set of fewer
// than two samples skips the variance and the root.
// The result sits in an output register; new samples are taken while it
// waits. If the receiver stalls, the next finished result waits in the
// finish sequence until the register is free, with in_ready low.
// Reset (synchronous, rst_n low) clears the sums, count, overflow flag and
// mode, and drops out_valid.
`timescale 1ns / 1ps
`default_nettype none

module sample_mean_variance_stddev_unit (
  input  logic       clk,
  input  logic       rst_n,
  smvs_cfg_if.sink   cfg_chan,
  smvs_in_if.sink    in_chan,
  smvs_out_if.source out_chan
);
  import smvs_pkg::*;

  state_t                     state_r, state_nxt;
  mul_step_t                  step_r;
  logic                       pop_mode_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic [SQ_W-1:0]            sq_r;
  logic [COUNT_W-1:0]         cnt_r;
  logic                       ovf_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic                       last_r;

  logic [MUL_W-1:0]           mul_a, mul_b;
  logic [PROD_W-1:0]          prod_r;
  logic [ACC_W-1:0]           acc_r;
  logic [DVS_W-1:0]           divisor_r;

  logic [DVD_W-1:0]           dvd_r;
  logic [DVS_W-1:0]           rem_r;
  logic [DVS_W-1:0]           dvs_r;
  logic [IT_W-1:0]            it_r;
  logic [ROOT_W-1:0]          rad_r, root_r, rbit_r;

  logic [MEAN_W-1:0]          mean_r;
  logic [VAR_W-1:0]           var_r;
  logic [DEV_W-1:0]           dev_r;

  logic                       out_valid_r;
  logic [MEAN_W-1:0]          out_mean_r;
  logic [VAR_W-1:0]           out_var_r;
  logic [DEV_W-1:0]           out_dev_r;
  logic [COUNT_W-1:0]         out_cnt_r;
  status_t                    out_status_r;

  logic                       in_rdy;
  logic                       out_load;
  logic                       it_done;
  logic                       few;
  logic [SUM_W-1:0]           smag;
  logic [SAMPLE_W-1:0]        in_mag;
  logic [DVS_W:0]             rem_sh, rem_sub;
  logic                       rem_ge;
  logic [ROOT_W-1:0]          root_trial;
  logic                       root_take;
  logic [MEAN_NUM_W-1:0]      mean_q, mean_up, mean_neg;
  logic [MEAN_W-1:0]          mean_val;
  logic [DIFF_W-1:0]          diff;
  status_t                    status_val;

  assign smag    = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign in_mag  = in_chan.sample[SAMPLE_W-1] ? SAMPLE_W'(-in_chan.sample)
                                              : SAMPLE_W'(in_chan.sample);
  assign it_done = (it_r == '0);
  assign few     = (cnt_r < COUNT_W'(2));

  // restoring divider, one quotient bit per cycle
  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, dvs_r});
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  // bit-pair square root
  assign root_trial = root_r + rbit_r;
  assign root_take  = (rad_r >= root_trial);

  assign mean_q   = dvd_r[MEAN_NUM_W-1:0];
  assign mean_up  = mean_q + MEAN_NUM_W'(rem_r != '0);
  assign mean_neg = '0 - mean_up;
  assign diff     = acc_r[ACC_W-1] ? '0 : acc_r[DIFF_W-1:0];

  always_comb begin
    if (cnt_r == '0) begin
      mean_val = '0;
    end else if (sum_r[SUM_W-1]) begin
      mean_val = mean_neg[MEAN_W-1:0];
    end else begin
      mean_val = mean_q[MEAN_W-1:0];
    end
  end

  always_comb begin
    priority if (ovf_r) begin
      status_val = STAT_OVF;
    end else if (few) begin
      status_val = STAT_FEW;
    end else begin
      status_val = STAT_OK;
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_IDLE) begin
      mul_a = MUL_W'(in_mag);
      mul_b = MUL_W'(in_mag);
    end else if (state_r == ST_MUL) begin
      unique case (step_r)
        MS_DIVISOR: begin
          mul_a = MUL_W'(cnt_r);
          mul_b = pop_mode_r ? MUL_W'(cnt_r) : MUL_W'(cnt_r - COUNT_W'(1));
        end
        MS_SQ_LO: begin
          mul_a = MUL_W'(cnt_r);
          mul_b = sq_r[MUL_W-1:0];
        end
        MS_SQ_HI: begin
          mul_a = MUL_W'(cnt_r);
          mul_b = MUL_W'(sq_r[SQ_W-1:MUL_W]);
        end
        MS_SM_LL: begin
          mul_a = smag[MUL_W-1:0];
          mul_b = smag[MUL_W-1:0];
        end
        MS_SM_LH: begin
          mul_a = smag[MUL_W-1:0];
          mul_b = MUL_W'(smag[SUM_W-1:MUL_W]);
        end
        MS_SM_HH: begin
          mul_a = MUL_W'(smag[SUM_W-1:MUL_W]);
          mul_b = MUL_W'(smag[SUM_W-1:MUL_W]);
        end
        MS_DRAIN: begin
          mul_a = '0;
          mul_b = '0;
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_rdy    = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_rdy = 1'b1;
        if (in_chan.valid) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        state_nxt = last_r ? ST_MUL : ST_IDLE;
      end
      ST_MUL: begin
        if (step_r == MS_DRAIN) begin
          state_nxt = ST_MEAN;
        end
      end
      ST_MEAN: begin
        if (it_done) begin
          state_nxt = few ? ST_OUT : ST_VAR;
        end
      end
      ST_VAR: begin
        if (it_done) begin
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (it_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pop_mode_r  <= 1'b0;
      sum_r       <= '0;
      sq_r        <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_chan.valid) begin
        pop_mode_r <= cfg_chan.population_mode;
      end
      if (state_r == ST_ACC) begin
        if (cnt_r < COUNT_W'(MAX_COUNT)) begin
          sum_r <= sum_r + SUM_W'(sample_r);
          sq_r  <= sq_r + SQ_W'(prod_r[2*SAMPLE_W-1:0]);
          cnt_r <= cnt_r + COUNT_W'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (out_load) begin
        sum_r       <= '0;
        sq_r        <= '0;
        cnt_r       <= '0;
        ovf_r       <= 1'b0;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;

    if (in_rdy && in_chan.valid) begin
      sample_r <= in_chan.sample;
      last_r   <= in_chan.last;
    end

    if (state_r == ST_ACC) begin
      step_r <= MS_DIVISOR;
      acc_r  <= '0;
    end

    if (state_r == ST_MUL) begin
      if (step_r != MS_DRAIN) begin
        step_r <= mul_step_t'(step_r + 3'd1);
      end
      // product of the previous step lands here
      unique case (step_r)
        MS_DIVISOR: ;
        MS_SQ_LO: divisor_r <= prod_r[DVS_W-1:0];
        MS_SQ_HI: acc_r <= acc_r + ACC_W'(prod_r);
        MS_SM_LL: acc_r <= acc_r + (ACC_W'(prod_r) << MUL_W);
        MS_SM_LH: acc_r <= acc_r - ACC_W'(prod_r);
        MS_SM_HH: acc_r <= acc_r - (ACC_W'(prod_r) << (MUL_W + 1));
        MS_DRAIN: begin
          acc_r <= acc_r - (ACC_W'(prod_r) << (2 * MUL_W));
          dvd_r <= {smag, {FRAC_W{1'b0}}, {(DVD_W - MEAN_NUM_W){1'b0}}};
          rem_r <= '0;
          dvs_r <= DVS_W'(cnt_r);
          it_r  <= IT_W'(MEAN_NUM_W);
        end
        default: ;
      endcase
    end

    if ((state_r == ST_MEAN || state_r == ST_VAR) && !it_done) begin
      dvd_r <= {dvd_r[DVD_W-2:0], rem_ge};
      rem_r <= rem_ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      it_r  <= it_r - IT_W'(1);
    end

    if (state_r == ST_MEAN && it_done) begin
      mean_r <= mean_val;
      if (few) begin
        var_r <= '0;
        dev_r <= '0;
      end else begin
        dvd_r <= {diff, {VAR_SHIFT{1'b0}}};
        rem_r <= '0;
        dvs_r <= divisor_r;
        it_r  <= IT_W'(DVD_W);
      end
    end

    if (state_r == ST_VAR && it_done) begin
      var_r  <= dvd_r[VAR_W+FRAC_W-1:FRAC_W];
      rad_r  <= dvd_r[ROOT_W-1:0];
      root_r <= '0;
      rbit_r <= ROOT_W'(1) << (ROOT_W - 2);
      it_r   <= IT_W'(ROOT_STEPS);
    end

    if (state_r == ST_ROOT) begin
      if (!it_done) begin
        if (root_take) begin
          rad_r  <= rad_r - root_trial;
          root_r <= (root_r >> 1) + rbit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        rbit_r <= rbit_r >> 2;
        it_r   <= it_r - IT_W'(1);
      end else begin
        dev_r <= root_r[DEV_W-1:0];
      end
    end

    if (out_load) begin
      out_mean_r   <= mean_r;
      out_var_r    <= var_r;
      out_dev_r    <= dev_r;
      out_cnt_r    <= cnt_r;
      out_status_r <= status_val;
    end
  end

  assign cfg_chan.ready          = 1'b1;
  assign in_chan.ready           = in_rdy;
  assign out_chan.valid          = out_valid_r;
  assign out_chan.mean_value     = out_mean_r;
  assign out_chan.variance_value = out_var_r;
  assign out_chan.std_dev        = out_dev_r;
  assign out_chan.sample_count   = out_cnt_r;
  assign out_chan.status         = out_status_r;

endmodule

`default_nettype wire

// File: hw/rtl/smvs_checker.sv
// Port checker for the mean/variance unit and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "sample_mean_variance_stddev_unit_macros.svh"

module smvs_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           in_last,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [smvs_pkg::MEAN_W-1:0]    out_mean,
  input logic [smvs_pkg::VAR_W-1:0]     out_variance,
  input logic [smvs_pkg::DEV_W-1:0]     out_std_dev,
  input logic [smvs_pkg::COUNT_W-1:0]   out_count,
  input logic [smvs_pkg::STATUS_W-1:0]  out_status
);
  import smvs_pkg::*;

  localparam int SQ2_W = 2 * DEV_W;

  logic [SQ2_W-1:0] dev_sq;

  assign dev_sq = SQ2_W'(out_std_dev) * SQ2_W'(out_std_dev);

  `SMVS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_mean) && $stable(out_variance) && $stable(out_std_dev) && $stable(out_count) && $stable(out_status), "stalled result word changed")
  `SMVS_ASSERT_IMP(a_ok_count, clk, rst_n, out_valid && out_status == STAT_OK, out_count >= COUNT_W'(2), "ok status with fewer than two samples")
  `SMVS_ASSERT_IMP(a_few_zero, clk, rst_n, out_valid && out_status == STAT_FEW, out_variance == '0 && out_std_dev == '0 && out_count < COUNT_W'(2), "short set gave nonzero spread")
  `SMVS_ASSERT_IMP(a_dev_bound, clk, rst_n, out_valid, (dev_sq >> FRAC_W) <= SQ2_W'(out_variance), "deviation squared exceeds variance")
  `SMVS_ASSERT_NXT(a_no_early, clk, rst_n, in_valid && in_ready && !in_last, !$rose(out_valid), "result after a word that does not end a set")

endmodule

bind sample_mean_variance_stddev_unit smvs_checker u_smvs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .in_last      (in_chan.last),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_mean     (out_chan.mean_value),
  .out_variance (out_chan.variance_value),
  .out_std_dev  (out_chan.std_dev),
  .out_count    (out_chan.sample_count),
  .out_status   (out_chan.status)
);

`default_nettype wire
